### design/aed_pkg.sv
// ----------------------------------------------------------------------------
// aed_pkg
// types, constants and fixed-point helpers of the ask edge demodulator
// ----------------------------------------------------------------------------
package aed_pkg;

    localparam int unsigned QW = 27;

    localparam logic [15:0] MID_RST     = 16'd2048;
    localparam logic [15:0] ATT_DEF     = 16'd52429;
    localparam logic [15:0] PRA_DEF     = 16'd197;
    localparam logic [15:0] TRA_DEF     = 16'd328;
    localparam logic [15:0] WM_DEF      = 16'd4915;
    localparam logic [15:0] WE_DEF      = 16'd11469;
    localparam int unsigned RISE_RUN_DEF = 2;
    localparam int unsigned FALL_RUN_DEF = 2;

    localparam logic [2:0] REG_MID  = 3'd0;
    localparam logic [2:0] REG_BIAS = 3'd1;
    localparam logic [2:0] REG_ATT  = 3'd2;
    localparam logic [2:0] REG_PRA  = 3'd3;
    localparam logic [2:0] REG_TRA  = 3'd4;
    localparam logic [2:0] REG_WM   = 3'd5;
    localparam logic [2:0] REG_WE   = 3'd6;

    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_RISE = 2'd1;
    localparam logic [1:0] EDGE_FALL = 2'd2;

    typedef logic signed [QW-1:0] t_q;

    typedef struct packed {
        logic [15:0] sample;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic        level;
        logic [1:0]  edge_res;
        logic        transition;
        logic [31:0] gap_samples;
        logic [31:0] last_edge_ms;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ENV, ST_THR, ST_DEC, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic env;
        logic thr;
        logic dec;
    } t_cmd;

    function automatic t_q sat_q(input logic signed [47:0] v);
        if (v > 48'sd67108863)       return 27'sd67108863;
        else if (v < -48'sd67108864) return -27'sd67108864;
        else                         return v[QW-1:0];
    endfunction

endpackage

### design/aed_ctrl.sv
// ----------------------------------------------------------------------------
// aed_ctrl
// sequencer: load, envelope step, threshold step, decision, result hold
// ----------------------------------------------------------------------------
module aed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_stall,
    output logic          o_in_stall,
    output logic          o_valid,
    output aed_pkg::t_cmd o_cmd
);
    aed_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aed_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        o_valid    = 1'b0;
        unique case (r_state)
            aed_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = aed_pkg::ST_ENV;
                end
            end
            aed_pkg::ST_ENV: begin
                o_cmd.env = 1'b1;
                n_state   = aed_pkg::ST_THR;
            end
            aed_pkg::ST_THR: begin
                o_cmd.thr = 1'b1;
                n_state   = aed_pkg::ST_DEC;
            end
            aed_pkg::ST_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = aed_pkg::ST_OUT;
            end
            aed_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = aed_pkg::ST_IDLE;
                end
            end
            default: n_state = aed_pkg::ST_IDLE;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.env, o_cmd.thr, o_cmd.dec}))
        else $error("more than one datapath command");
    a_env_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.env)
        else $error("envelope step did not follow load");
    a_out_after_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.dec |=> o_valid)
        else $error("result not presented after decision");
endmodule

### design/aed_dp.sv
// ----------------------------------------------------------------------------
// aed_dp
// envelope, threshold and run-length datapath with configuration registers
// ----------------------------------------------------------------------------
module aed_dp #(
    parameter int unsigned RISE_RUN = aed_pkg::RISE_RUN_DEF,
    parameter int unsigned FALL_RUN = aed_pkg::FALL_RUN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aed_pkg::t_cmd i_cmd,
    input  aed_pkg::t_in  i_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output aed_pkg::t_out o_data
);
    localparam logic [7:0] RISE_N = (RISE_RUN % 256 == 0) ? 8'd1 : 8'(RISE_RUN % 256);
    localparam logic [7:0] FALL_N = (FALL_RUN % 256 == 0) ? 8'd1 : 8'(FALL_RUN % 256);

    logic [15:0] r_mid, r_bias, r_att, r_pra, r_tra, r_wm, r_we;
    logic [15:0] r_smp;
    logic [31:0] r_now, r_cnt, r_last_idx, r_edge_time;
    logic        r_seen, r_level;
    logic [7:0]  r_above, r_below;
    aed_pkg::t_q r_peak, r_trough, r_upper, r_lower;
    aed_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid  <= aed_pkg::MID_RST;
            r_bias <= '0;
            r_att  <= aed_pkg::ATT_DEF;
            r_pra  <= aed_pkg::PRA_DEF;
            r_tra  <= aed_pkg::TRA_DEF;
            r_wm   <= aed_pkg::WM_DEF;
            r_we   <= aed_pkg::WE_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aed_pkg::REG_MID:  r_mid  <= i_cfg_data;
                aed_pkg::REG_BIAS: r_bias <= i_cfg_data;
                aed_pkg::REG_ATT:  r_att  <= i_cfg_data;
                aed_pkg::REG_PRA:  r_pra  <= i_cfg_data;
                aed_pkg::REG_TRA:  r_tra  <= i_cfg_data;
                aed_pkg::REG_WM:   r_wm   <= i_cfg_data;
                aed_pkg::REG_WE:   r_we   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample and limits in q20.8
    logic signed [27:0] s_q, mid_q, bias_q, hi_t, lo_t;
    assign s_q    = {4'd0, r_smp, 8'd0};
    assign mid_q  = {4'd0, r_mid, 8'd0};
    assign bias_q = {4'd0, r_bias, 8'd0};
    assign hi_t   = mid_q + bias_q;
    assign lo_t   = mid_q - bias_q;

    logic        pk_att, tr_att;
    logic [15:0] att, pra, tra, pa, ta;
    logic signed [28:0] pd, td;
    logic signed [47:0] pp, tp, pn, tn;
    assign att    = (r_att == 16'd0) ? aed_pkg::ATT_DEF : r_att;
    assign pra    = (r_pra == 16'd0) ? aed_pkg::PRA_DEF : r_pra;
    assign tra    = (r_tra == 16'd0) ? aed_pkg::TRA_DEF : r_tra;
    assign pk_att = s_q > 28'(r_peak);
    assign tr_att = s_q < 28'(r_trough);
    assign pa     = pk_att ? att : pra;
    assign ta     = tr_att ? att : tra;
    assign pd     = 29'(pk_att ? s_q : hi_t) - 29'(r_peak);
    assign td     = 29'(tr_att ? s_q : lo_t) - 29'(r_trough);
    assign pp     = 48'(pd) * $signed({1'b0, pa});
    assign tp     = 48'(td) * $signed({1'b0, ta});
    // round half up then shift
    assign pn     = 48'(r_peak) + ((pp + 48'sd32768) >>> 16);
    assign tn     = 48'(r_trough) + ((tp + 48'sd32768) >>> 16);

    logic        wz;
    logic [15:0] wm, we;
    logic signed [47:0] base, us, ls;
    aed_pkg::t_q up_s, lo_s;
    assign wz   = (r_wm == 16'd0) && (r_we == 16'd0);
    assign wm   = wz ? aed_pkg::WM_DEF : r_wm;
    assign we   = wz ? aed_pkg::WE_DEF : r_we;
    assign base = 48'(mid_q) * $signed({1'b0, wm});
    assign us   = base + 48'(r_peak) * $signed({1'b0, we});
    assign ls   = base + 48'(r_trough) * $signed({1'b0, we});
    assign up_s = aed_pkg::sat_q((us + 48'sd8192) >>> 14);
    assign lo_s = aed_pkg::sat_q((ls + 48'sd8192) >>> 14);

    // run counters and level decision
    logic [7:0]  ab1, be1, ab2, be2;
    logic        lv1, lv2, rise_ev, fall_ev;
    always_comb begin
        ab1 = (s_q > 28'(r_upper)) ? ((r_above < RISE_N) ? r_above + 8'd1 : r_above) : 8'd0;
        be1 = r_below;
        lv1 = r_level;
        rise_ev = 1'b0;
        if (ab1 >= RISE_N) begin
            be1 = 8'd0;
            if (!r_level) begin
                rise_ev = 1'b1;
                lv1     = 1'b1;
            end
        end
        be2 = (s_q < 28'(r_lower)) ? ((be1 < FALL_N) ? be1 + 8'd1 : be1) : 8'd0;
        ab2 = ab1;
        lv2 = lv1;
        fall_ev = 1'b0;
        if (be2 >= FALL_N) begin
            ab2 = 8'd0;
            if (lv1) begin
                fall_ev = 1'b1;
                lv2     = 1'b0;
            end
        end
    end

    logic trans;
    assign trans = rise_ev | fall_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_last_idx  <= '0;
            r_edge_time <= '0;
            r_seen      <= 1'b0;
            r_level     <= 1'b0;
            r_above     <= '0;
            r_below     <= '0;
            r_peak      <= aed_pkg::t_q'({aed_pkg::MID_RST, 8'd0});
            r_trough    <= aed_pkg::t_q'({aed_pkg::MID_RST, 8'd0});
            r_upper     <= aed_pkg::t_q'({aed_pkg::MID_RST, 8'd0});
            r_lower     <= aed_pkg::t_q'({aed_pkg::MID_RST, 8'd0});
        end else begin
            if (i_cmd.load) begin
                r_cnt <= r_cnt + 32'd1;
            end
            if (i_cmd.env) begin
                r_peak   <= aed_pkg::sat_q(pn);
                r_trough <= aed_pkg::sat_q(tn);
            end
            if (i_cmd.thr) begin
                if (up_s <= lo_s) begin
                    r_upper <= aed_pkg::t_q'(mid_q + 28'sd256);
                    r_lower <= aed_pkg::t_q'(mid_q - 28'sd256);
                end else begin
                    r_upper <= up_s;
                    r_lower <= lo_s;
                end
            end
            if (i_cmd.dec) begin
                r_above <= ab2;
                r_below <= be2;
                r_level <= lv2;
                if (trans) begin
                    r_last_idx  <= r_cnt;
                    r_seen      <= 1'b1;
                    r_edge_time <= r_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp <= i_data.sample;
            r_now <= i_data.now_ms;
        end
        if (i_cmd.dec) begin
            r_out.level        <= lv2;
            r_out.edge_res     <= fall_ev ? aed_pkg::EDGE_FALL :
                                  (rise_ev ? aed_pkg::EDGE_RISE : aed_pkg::EDGE_NONE);
            r_out.transition   <= trans;
            r_out.gap_samples  <= (trans && r_seen) ? r_cnt - r_last_idx : 32'd0;
            r_out.last_edge_ms <= trans ? r_now : r_edge_time;
        end
    end

    assign o_data = r_out;

    a_thr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.thr) && i_rst_n && $past(i_rst_n) |-> r_upper > r_lower)
        else $error("thresholds crossed after update");
    a_runs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_above <= RISE_N && r_below <= FALL_N)
        else $error("run counter past its limit");
    a_level_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.dec) && $past(i_rst_n) && r_out.transition |-> r_out.level == r_level)
        else $error("result level disagrees with state");
endmodule

### design/ask_envelope_edge_demodulator_top.sv
// ----------------------------------------------------------------------------
// ask_envelope_edge_demodulator_top
// ask envelope threshold demodulator with run-length edge qualification
// ----------------------------------------------------------------------------
// sequence: after the input transfer come the envelope, threshold and decision
//   steps, the decision writing the result register, which is held until taken
// flow: no new sample is taken until the result has transferred, so an output stall
//   holds the input too; the sequencer steps one sample through the shared datapath
// reset: synchronous active low, registers to defaults, envelopes to midpoint
module ask_envelope_edge_demodulator_top #(
    parameter int unsigned RISE_RUN = aed_pkg::RISE_RUN_DEF,
    parameter int unsigned FALL_RUN = aed_pkg::FALL_RUN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input channel
    input  logic          i_valid,
    output logic          o_stall,
    input  aed_pkg::t_in  i_data,
    // result channel
    output logic          o_valid,
    input  logic          i_stall,
    output aed_pkg::t_out o_data,
    // configuration writes
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    // commands from sequencer to datapath
    aed_pkg::t_cmd w_cmd;

    aed_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .o_in_stall  (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (w_cmd)
    );

    aed_dp #(
        .RISE_RUN (RISE_RUN),
        .FALL_RUN (FALL_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (o_data)
    );
endmodule

### test/tb_ask_envelope_edge_demodulator_top.sv
// ----------------------------------------------------------------------------
// tb_ask_envelope_edge_demodulator_top
// self-checking bench of the ask envelope edge demodulator
// ----------------------------------------------------------------------------
// a directed table of samples runs first, then random bursts of ask-like
// amplitude sequences under several register settings and idling phases.
// every result transfer is compared field by field against a bit-true
// model of the envelope tracker, thresholds and run-length qualifier.
// ----------------------------------------------------------------------------
module tb_ask_envelope_edge_demodulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RISE_N = aed_pkg::RISE_RUN_DEF;
    localparam int unsigned FALL_N = aed_pkg::FALL_RUN_DEF;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam longint LIMIT_CYCLES = 400000;
    localparam longint Q_HI = 67108863;
    localparam longint Q_LO = -67108864;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    aed_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    aed_pkg::t_out o_data;
    logic          i_cfg_we;
    logic [2:0]    i_cfg_index;
    logic [15:0]   i_cfg_data;

    ask_envelope_edge_demodulator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow registers of the demodulator
    logic [15:0] mid_reg, bias_reg, att_reg, pra_reg, tra_reg, wm_reg, we_reg;
    logic [31:0] n_samples, last_edge_idx, edge_ms;
    logic        edge_seen, lvl;
    int unsigned run_hi, run_lo;
    longint      peak_q, trough_q, upper_q, lower_q;

    aed_pkg::t_out expected_results[$];
    int    errors = 0;
    int    results_seen = 0;
    int    edges_seen = 0;
    longint cycle_count = 0;

    // idling controls, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off = 0;
    int unsigned hold_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // overall watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sat27(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // round half up then shift, floor semantics on negative values
    function automatic longint rnd_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint env_follow(input longint env, input longint tgt,
                                          input logic [15:0] alpha);
        return sat27(env + rnd_shift((tgt - env) * longint'(alpha), 16));
    endfunction

    task automatic reset_model();
        mid_reg = aed_pkg::MID_RST; bias_reg = 16'd0; att_reg = aed_pkg::ATT_DEF;
        pra_reg = aed_pkg::PRA_DEF; tra_reg = aed_pkg::TRA_DEF;
        wm_reg = aed_pkg::WM_DEF; we_reg = aed_pkg::WE_DEF;
        n_samples = 0; last_edge_idx = 0; edge_ms = 0;
        edge_seen = 0; lvl = 0; run_hi = 0; run_lo = 0;
        peak_q = longint'(aed_pkg::MID_RST) * 256;
        trough_q = peak_q; upper_q = peak_q; lower_q = peak_q;
    endtask

    task automatic model_cfg(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            aed_pkg::REG_MID:  mid_reg = val;
            aed_pkg::REG_BIAS: bias_reg = val;
            aed_pkg::REG_ATT:  att_reg = val;
            aed_pkg::REG_PRA:  pra_reg = val;
            aed_pkg::REG_TRA:  tra_reg = val;
            aed_pkg::REG_WM:   wm_reg = val;
            aed_pkg::REG_WE:   we_reg = val;
            default: ;
        endcase
    endtask

    // one sample through envelopes, thresholds and run qualifier
    function automatic aed_pkg::t_out demod_sample(input aed_pkg::t_in item);
        aed_pkg::t_out r;
        longint      s, m, b, base;
        logic [15:0] att, pra, tra, wm, we;
        logic        trans;
        logic [1:0]  edg;
        logic [31:0] gap;
        s = longint'(item.sample) * 256;
        m = longint'(mid_reg) * 256;
        b = longint'(bias_reg) * 256;
        att = (att_reg == 0) ? aed_pkg::ATT_DEF : att_reg;
        pra = (pra_reg == 0) ? aed_pkg::PRA_DEF : pra_reg;
        tra = (tra_reg == 0) ? aed_pkg::TRA_DEF : tra_reg;
        wm = wm_reg; we = we_reg;
        trans = 0; edg = aed_pkg::EDGE_NONE; gap = 0;
        n_samples = n_samples + 1;
        if (s > peak_q) peak_q = env_follow(peak_q, s, att);
        else            peak_q = env_follow(peak_q, m + b, pra);
        if (s < trough_q) trough_q = env_follow(trough_q, s, att);
        else              trough_q = env_follow(trough_q, m - b, tra);
        if (wm == 0 && we == 0) begin
            wm = aed_pkg::WM_DEF; we = aed_pkg::WE_DEF;
        end
        base = m * longint'(wm);
        upper_q = sat27(rnd_shift(base + peak_q * longint'(we), 14));
        lower_q = sat27(rnd_shift(base + trough_q * longint'(we), 14));
        // crossed thresholds fall back to midpoint plus or minus one
        if (upper_q <= lower_q) begin
            upper_q = m + 256;
            lower_q = m - 256;
        end
        if (s > upper_q) begin
            if (run_hi < RISE_N) run_hi++;
        end else run_hi = 0;
        if (run_hi >= RISE_N) begin
            run_lo = 0;
            if (!lvl) begin
                edg = aed_pkg::EDGE_RISE; trans = 1; lvl = 1;
            end
        end
        if (s < lower_q) begin
            if (run_lo < FALL_N) run_lo++;
        end else run_lo = 0;
        if (run_lo >= FALL_N) begin
            run_hi = 0;
            if (lvl) begin
                edg = aed_pkg::EDGE_FALL; trans = 1; lvl = 0;
            end
        end
        if (trans) begin
            if (edge_seen) gap = n_samples - last_edge_idx;
            last_edge_idx = n_samples;
            edge_seen = 1;
            edge_ms = item.now_ms;
        end
        r.level = lvl; r.edge_res = edg; r.transition = trans;
        r.gap_samples = gap; r.last_edge_ms = edge_ms;
        return r;
    endfunction

    // receiver: random stall, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_off) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker, sampled at the edge where the transfer happens
    always @(posedge i_clk) begin
        aed_pkg::t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_data.transition) edges_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_data);
            end else begin
                e = expected_results.pop_front();
                if (o_data.level !== e.level) begin
                    errors++;
                    $display("%0t: level exp %0d got %0d", $time, e.level, o_data.level);
                end
                if (o_data.edge_res !== e.edge_res) begin
                    errors++;
                    $display("%0t: edge exp %0d got %0d", $time, e.edge_res,
                             o_data.edge_res);
                end
                if (o_data.transition !== e.transition) begin
                    errors++;
                    $display("%0t: transition exp %0d got %0d", $time, e.transition,
                             o_data.transition);
                end
                if (o_data.gap_samples !== e.gap_samples) begin
                    errors++;
                    $display("%0t: gap exp %0d got %0d", $time, e.gap_samples,
                             o_data.gap_samples);
                end
                if (o_data.last_edge_ms !== e.last_edge_ms) begin
                    errors++;
                    $display("%0t: edge time exp %h got %h", $time, e.last_edge_ms,
                             o_data.last_edge_ms);
                end
            end
        end
    end

    // offer one item, wait for its transfer; prediction made at acceptance
    // valid stays high after the transfer until the next item or the drain
    task automatic send_item(input aed_pkg::t_in item, input bit pinned,
                             input aed_pkg::t_out pin_val);
        aed_pkg::t_out p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        p = demod_sample(item);
        // typed-in rows double-check the predictor too
        if (pinned && p !== pin_val) begin
            errors++;
            $display("%0t: table row exp %h model %h", $time, pin_val, p);
        end
        expected_results.push_back(p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_cfg(idx, val);
        @(posedge i_clk);
    endtask

    // ask-like burst: runs of high and low amplitude with noise
    task automatic send_burst(input int n, input logic [15:0] hi_amp,
                              input logic [15:0] lo_amp, input logic [31:0] t0);
        aed_pkg::t_in  it;
        aed_pkg::t_out none;
        int  run;
        bit  hi;
        logic [31:0] t;
        hi = 1'($urandom_range(1)); t = t0; none = '0;
        while (n > 0) begin
            run = $urandom_range(12, 1);
            repeat (run) begin
                if (n > 0) begin
                    if ($urandom_range(9) == 0) it.sample = 16'($urandom);
                    else if (hi) it.sample = hi_amp - 16'($urandom_range(300));
                    else it.sample = lo_amp + 16'($urandom_range(300));
                    t = t + $urandom_range(3);
                    it.now_ms = ($urandom_range(19) == 0) ? 32'($urandom) : t;
                    send_item(it, 0, none);
                    n--;
                end
            end
            hi = ~hi;
        end
    endtask

    typedef struct {
        logic [15:0]   sample;
        logic [31:0]   now_ms;
        bit            pinned;
        aed_pkg::t_out result;
    } t_row;

    t_row dir_rows[] = '{
        // first sample at midpoint: nothing moves
        '{16'd2048, 32'h0000_0001, 1,
          '{1'b0, aed_pkg::EDGE_NONE, 1'b0, 32'd0, 32'd0}},
        '{16'hFFFF, 32'h0000_0002, 0, '0},
        '{16'hFFFF, 32'hFFFF_FFFF, 0, '0},
        '{16'hFFFF, 32'h0000_0010, 0, '0},
        '{16'h0000, 32'h0000_0000, 0, '0},
        '{16'h0000, 32'hAAAA_5555, 0, '0},
        '{16'h0000, 32'h5555_AAAA, 0, '0},
        '{16'hFFFF, 32'h8000_0000, 0, '0},
        '{16'h0000, 32'h0000_0020, 0, '0},
        '{16'hFFFF, 32'h0000_0021, 0, '0},
        '{16'hFFFF, 32'h0000_0022, 0, '0},
        '{16'h0001, 32'h0000_0023, 0, '0},
        '{16'h0001, 32'h0000_0024, 0, '0},
        '{16'h8000, 32'h0000_0025, 0, '0},
        '{16'h7FFF, 32'h0000_0026, 0, '0},
        '{16'hFFFE, 32'h0000_0027, 0, '0},
        '{16'hFFFE, 32'h0000_0028, 0, '0}
    };

    initial begin
        aed_pkg::t_in it;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings, no idling
        foreach (dir_rows[k]) begin
            it.sample = dir_rows[k].sample;
            it.now_ms = dir_rows[k].now_ms;
            send_item(it, dir_rows[k].pinned, dir_rows[k].result);
        end
        drain();

        // zero alphas fall back, zero weights fall back, ignored index
        write_reg(aed_pkg::REG_ATT, 16'd0); write_reg(aed_pkg::REG_PRA, 16'd0);
        write_reg(aed_pkg::REG_TRA, 16'd0); write_reg(aed_pkg::REG_WM, 16'd0);
        write_reg(aed_pkg::REG_WE, 16'd0); write_reg(3'd7, 16'hFFFF);
        send_burst(20, 16'hF000, 16'h0100, 32'd1000);
        drain();

        // extremes: top midpoint and bias, full-scale alphas and weights
        write_reg(aed_pkg::REG_MID, 16'hFFFF); write_reg(aed_pkg::REG_BIAS, 16'hFFFF);
        write_reg(aed_pkg::REG_ATT, 16'hFFFF); write_reg(aed_pkg::REG_PRA, 16'hFFFF);
        write_reg(aed_pkg::REG_TRA, 16'hFFFF); write_reg(aed_pkg::REG_WM, 16'hFFFF);
        write_reg(aed_pkg::REG_WE, 16'hFFFF);
        send_burst(20, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0);
        drain();

        // crossed thresholds: weights that pull both sums to the midpoint
        write_reg(aed_pkg::REG_MID, 16'd0); write_reg(aed_pkg::REG_BIAS, 16'd0);
        write_reg(aed_pkg::REG_WM, 16'd1); write_reg(aed_pkg::REG_WE, 16'd0);
        send_burst(15, 16'd4000, 16'd0, 32'd50);
        drain();

        // phase of no idling, typical settings
        write_reg(aed_pkg::REG_MID, 16'd2048); write_reg(aed_pkg::REG_BIAS, 16'd200);
        write_reg(aed_pkg::REG_ATT, 16'd52429); write_reg(aed_pkg::REG_PRA, 16'd197);
        write_reg(aed_pkg::REG_TRA, 16'd328); write_reg(aed_pkg::REG_WM, 16'd4915);
        write_reg(aed_pkg::REG_WE, 16'd11469);
        send_burst(150, 16'd3800, 16'd300, 32'd0);
        drain();

        // sender idle most of the time, faster release
        send_idle_pct = 56;
        write_reg(aed_pkg::REG_PRA, 16'd4000); write_reg(aed_pkg::REG_TRA, 16'd4000);
        write_reg(aed_pkg::REG_MID, 16'd20000);
        send_burst(150, 16'd40000, 16'd2000, 32'd100000);
        drain();

        // receiver stalls most of the time, with one long hold-off first
        send_idle_pct = 0; recv_stall_pct = 56;
        hold_off = 1;
        fork
            send_burst(150, 16'd60000, 16'd1000, 32'h7FFF_0000);
            begin
                while (hold_cycles < 300) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();

        // both sides idle, random registers
        send_idle_pct = 18; recv_stall_pct = 18;
        write_reg(aed_pkg::REG_MID, 16'($urandom_range(30000)));
        write_reg(aed_pkg::REG_BIAS, 16'($urandom_range(2000)));
        write_reg(aed_pkg::REG_ATT, 16'($urandom_range(65535, 20000)));
        write_reg(aed_pkg::REG_WM, 16'($urandom_range(8000)));
        write_reg(aed_pkg::REG_WE, 16'($urandom_range(16000)));
        send_burst(150, 16'd62000, 16'd500, 32'($urandom));
        drain();

        $display("covered %0d results with %0d level transitions", results_seen,
                 edges_seen);
        $display("register extremes, fallbacks, threshold crossing and stalls exercised");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
